// ----- rtl/pffla_pkg.sv -----
// Package for the page frame free-list allocator.
// Holds field widths, page geometry and the request/status codes.
// No dependencies.
package pffla_pkg;

  localparam int ADDR_W     = 39;
  localparam int AMT_W      = 20;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC_PAGES = 2'd0,
    FUNC_ALLOC_BYTES = 2'd1,
    FUNC_FREE_PAGE   = 2'd2,
    FUNC_NOP         = 2'd3
  } func_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

endpackage

// ----- rtl/pffla_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the free-list next-link store. No dependencies.
module pffla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/page_frame_free_list_allocator_core.sv -----
// Page frame allocator: free list in a next-link RAM plus a bump pointer.
// Depends on pffla_pkg and pffla_ram.
//
// Usage:
//   Request channel: drive func, amount and page_address and raise start;
//   the transaction is taken at a rising edge where start is high and busy
//   is low. busy stays high for the one cycle the request is worked on.
//   Result channel: done pulses for one cycle with address and status; the
//   result is registered at the edge that ends ST_EXEC and is taken at the
//   next edge, since the receiver has no way to stall it.
//   The next request waits until busy falls. The head's next link is read
//   from the next-link RAM at the accepting edge and used in the following
//   cycle, when the head, tail, bump pointer and RAM write are updated.
//   Configuration: cfg_wr_en/cfg_wr_data write pool_base and pool_end (and
//   load the bump pointer); the user must do so while idle (not enforced).
//   Reset (rst, synchronous): empties the free list, clears pool_base and
//   the bump pointer. The next-link RAM needs no clearing, since an entry
//   is always written before the list can reach it.
module page_frame_free_list_allocator_core #(
  parameter int POOL_PAGES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pffla_pkg::FUNC_W-1:0]      func,
  input  logic [pffla_pkg::AMT_W-1:0]       amount,
  input  logic [pffla_pkg::ADDR_W-1:0]      page_address,
  output logic                              done,
  output logic [pffla_pkg::ADDR_W-1:0]      address,
  output logic [pffla_pkg::STATUS_W-1:0]    status,
  input  logic                              cfg_wr_en,
  input  logic [pffla_pkg::ADDR_W-1:0]      cfg_wr_data
);

  localparam int AW  = pffla_pkg::ADDR_W;
  localparam int PS  = pffla_pkg::PAGE_SHIFT;
  localparam int IW  = $clog2(POOL_PAGES);
  localparam int QW  = AW - PS;
  localparam int EW  = AW + 1;
  localparam int SW  = AW + 2;
  localparam logic [EW-1:0] POOL_SPAN = EW'(POOL_PAGES) << PS;
  localparam logic [EW-1:0] PAGE_RND  = EW'(pffla_pkg::PAGE_BYTES - 1);
  localparam logic [EW-1:0] BYTE_RND  = EW'(3);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Configuration and allocator state
  logic [AW-1:0] pool_base;
  logic [EW-1:0] pool_end;
  logic [AW-1:0] bump_pointer;
  logic [IW-1:0] list_head;
  logic [IW-1:0] list_tail;
  logic          list_valid;

  // Captured request
  pffla_pkg::func_t   func_q;
  logic [pffla_pkg::AMT_W-1:0] amount_q;
  logic [AW-1:0]      page_address_q;

  logic          accept;
  logic [IW-1:0] link_rd_data;
  logic          link_wr_en;
  logic [IW-1:0] free_idx;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Next-link store: read the head's link at accept, append at the tail
  pffla_ram #(
    .WIDTH(IW),
    .DEPTH(POOL_PAGES)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (link_wr_en),
    .wr_addr(list_tail),
    .wr_data(free_idx),
    .rd_en  (accept),
    .rd_addr(list_head),
    .rd_data(link_rd_data)
  );

  // Page bump: round up to a page, then advance by amount pages
  logic [EW-1:0] page_round;
  logic [SW-1:0] page_sum;
  logic          page_full;
  assign page_round = ({1'b0, bump_pointer} + PAGE_RND) & ~PAGE_RND;
  assign page_sum   = {1'b0, page_round} +
                      {{(SW - pffla_pkg::AMT_W - PS){1'b0}}, amount_q, {PS{1'b0}}};
  assign page_full  = (page_round >= pool_end) || page_round[AW];

  // Byte bump: round up to 4, then advance by amount bytes
  logic [EW-1:0] byte_round;
  logic [SW-1:0] byte_sum;
  assign byte_round = ({1'b0, bump_pointer} + BYTE_RND) & ~BYTE_RND;
  assign byte_sum   = {1'b0, byte_round} + {{(SW - pffla_pkg::AMT_W){1'b0}}, amount_q};

  // List head address
  logic [EW-1:0] head_addr;
  assign head_addr = {1'b0, pool_base} + {{(EW - IW - PS){1'b0}}, list_head, {PS{1'b0}}};

  // Free: range check and page index
  logic [AW-1:0] free_off;
  logic [QW-1:0] free_q;
  logic          free_outside;
  assign free_off     = page_address_q - pool_base;
  assign free_q       = free_off[AW-1:PS];
  assign free_outside = (page_address_q < pool_base) ||
                        ({1'b0, page_address_q} >= pool_end) ||
                        (free_q >= QW'(POOL_PAGES));
  assign free_idx     = free_q[IW-1:0];

  assign link_wr_en = (state == ST_EXEC) && (func_q == pffla_pkg::FUNC_FREE_PAGE) &&
                      !free_outside && list_valid;

  // Saturate an advanced pointer to the address range
  function automatic logic [AW-1:0] sat_addr(input logic [SW-1:0] v);
    logic [SW-1:0] lim;
    lim = {2'b00, pffla_pkg::ADDR_MAX};
    if (v > lim) begin
      sat_addr = pffla_pkg::ADDR_MAX;
    end else begin
      sat_addr = v[AW-1:0];
    end
  endfunction

  // Sequencer, allocator state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      pool_base    <= '0;
      pool_end     <= POOL_SPAN;
      bump_pointer <= '0;
      list_head    <= '0;
      list_tail    <= '0;
      list_valid   <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
      if (cfg_wr_en) begin
        pool_base    <= cfg_wr_data;
        pool_end     <= {1'b0, cfg_wr_data} + POOL_SPAN;
        bump_pointer <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q         <= pffla_pkg::func_t'(func);
            amount_q       <= amount;
            page_address_q <= page_address;
            state          <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (func_q)
            pffla_pkg::FUNC_ALLOC_PAGES: begin
              if (list_valid) begin
                address <= head_addr[AW-1:0];
                status  <= pffla_pkg::STATUS_OK;
                if (list_head == list_tail) begin
                  list_valid <= 1'b0;
                  list_head  <= '0;
                  list_tail  <= '0;
                end else begin
                  list_head <= link_rd_data;
                end
              end else if (page_full) begin
                address <= '0;
                status  <= pffla_pkg::STATUS_FULL;
              end else begin
                address      <= page_round[AW-1:0];
                status       <= pffla_pkg::STATUS_OK;
                bump_pointer <= sat_addr(page_sum);
              end
            end
            pffla_pkg::FUNC_ALLOC_BYTES: begin
              if (byte_round[AW]) begin
                address <= '0;
                status  <= pffla_pkg::STATUS_FULL;
              end else begin
                address      <= byte_round[AW-1:0];
                status       <= pffla_pkg::STATUS_OK;
                bump_pointer <= sat_addr(byte_sum);
              end
            end
            pffla_pkg::FUNC_FREE_PAGE: begin
              address <= '0;
              if (free_outside) begin
                status <= pffla_pkg::STATUS_OUTSIDE;
              end else begin
                status    <= pffla_pkg::STATUS_OK;
                list_tail <= free_idx;
                if (!list_valid) begin
                  list_head  <= free_idx;
                  list_valid <= 1'b1;
                end
              end
            end
            default: begin
              address <= '0;
              status  <= pffla_pkg::STATUS_OK;
            end
          endcase
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result only follows a cycle of work
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == ST_EXEC))
    else $error("result strobe without a request in work");

  // An accepted transaction blocks the next one: busy is high in the following cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request accepted back to back");

  // An empty list keeps its head and tail cleared
  assert property (@(posedge clk) disable iff (rst)
    !list_valid |-> (list_head == '0 && list_tail == '0))
    else $error("empty free list with stale head or tail");

  // A full indication never carries an address
  assert property (@(posedge clk) disable iff (rst)
    (done && status == pffla_pkg::STATUS_FULL) |-> (address == '0))
    else $error("memory full result with nonzero address");
`endif

endmodule
